// ===== rtl/ipv4dq_pkg.sv =====
// Package with the constants and types shared by the dotted-quad parser modules.
package ipv4dq_pkg;

   // Longest string that can still be a valid address.
   localparam int unsigned MAX_CHARS = 15;

   // Field and state widths.
   localparam int unsigned CHAR_W        = 8;
   localparam int unsigned ADDR_W        = 32;
   localparam int unsigned OCTET_W       = 8;
   localparam int unsigned PARTIAL_W     = 24;
   localparam int unsigned CHAR_COUNT_W  = 4;
   localparam int unsigned DIGIT_COUNT_W = 2;
   localparam int unsigned FIELD_IDX_W   = 2;
   localparam int unsigned PRODUCT_W     = 12;

   // Character codes.
   localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

   // Limits of one field.
   localparam logic [DIGIT_COUNT_W-1:0] MAX_DIGITS = 2'd3;
   localparam logic [FIELD_IDX_W-1:0]   LAST_FIELD = 2'd3;
   localparam logic [PRODUCT_W-1:0]     OCTET_MAX  = 12'd255;
   localparam logic [CHAR_COUNT_W-1:0]  CHAR_LIMIT = CHAR_COUNT_W'(MAX_CHARS);

   // One parse result handed from the scanner to the output register.
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic              valid_res;
   } result_type;

endpackage

// ===== rtl/ipv4dq_field_scan.sv =====
// Per-character scanner that holds the parse state and forms the result on the last byte.
module ipv4dq_field_scan #(
   parameter int unsigned MAX_CHARS = ipv4dq_pkg::MAX_CHARS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  logic [ipv4dq_pkg::CHAR_W-1:0]     char_byte,
   input  logic                              last_byte,
   output ipv4dq_pkg::result_type            result
);

   // Count at which a further character makes the string too long.
   localparam logic [ipv4dq_pkg::CHAR_COUNT_W-1:0] CHAR_LIMIT =
      ipv4dq_pkg::CHAR_COUNT_W'(MAX_CHARS);

   logic [ipv4dq_pkg::OCTET_W-1:0]       octet_value_ff, octet_value_in;
   logic [ipv4dq_pkg::DIGIT_COUNT_W-1:0] digit_count_ff, digit_count_in;
   logic [ipv4dq_pkg::FIELD_IDX_W-1:0]   field_index_ff, field_index_in;
   logic [ipv4dq_pkg::PARTIAL_W-1:0]     partial_address_ff, partial_address_in;
   logic [ipv4dq_pkg::CHAR_COUNT_W-1:0]  char_count_ff, char_count_in;
   logic                                 leading_zero_ff, leading_zero_in;
   logic                                 error_seen_ff, error_seen_in;

   // Updated state after this character, before any end-of-string clear.
   logic [ipv4dq_pkg::OCTET_W-1:0]       octet_upd;
   logic [ipv4dq_pkg::DIGIT_COUNT_W-1:0] digit_upd;
   logic [ipv4dq_pkg::FIELD_IDX_W-1:0]   field_upd;
   logic [ipv4dq_pkg::PARTIAL_W-1:0]     partial_upd;
   logic [ipv4dq_pkg::CHAR_COUNT_W-1:0]  count_upd;
   logic                                 zero_upd;
   logic                                 error_upd;

   logic                                 is_digit;
   logic [ipv4dq_pkg::CHAR_W-1:0]        digit_val;
   logic [ipv4dq_pkg::PRODUCT_W-1:0]     field_sum;
   logic                                 addr_ok;

   // Classify the byte and form the next field value.
   assign is_digit  = (char_byte >= ipv4dq_pkg::CHAR_ZERO) &&
                      (char_byte <= ipv4dq_pkg::CHAR_NINE);
   assign digit_val = char_byte - ipv4dq_pkg::CHAR_ZERO;
   assign field_sum = ipv4dq_pkg::PRODUCT_W'(octet_value_ff) * 12'd10 +
                      ipv4dq_pkg::PRODUCT_W'(digit_val[3:0]);

   // Apply one character to the parse state.
   always_comb begin
      octet_upd   = octet_value_ff;
      digit_upd   = digit_count_ff;
      field_upd   = field_index_ff;
      partial_upd = partial_address_ff;
      count_upd   = char_count_ff;
      zero_upd    = leading_zero_ff;
      error_upd   = error_seen_ff;
      if (!error_seen_ff) begin
         if (char_count_ff >= CHAR_LIMIT) begin
            error_upd = 1'b1;
         end else begin
            count_upd = char_count_ff + 1'b1;
            if (is_digit) begin
               if (digit_count_ff == ipv4dq_pkg::MAX_DIGITS) begin
                  error_upd = 1'b1;
               end else if ((digit_count_ff != '0) && leading_zero_ff) begin
                  error_upd = 1'b1;
               end else if (field_sum > ipv4dq_pkg::OCTET_MAX) begin
                  error_upd = 1'b1;
               end else begin
                  octet_upd = field_sum[ipv4dq_pkg::OCTET_W-1:0];
                  digit_upd = digit_count_ff + 1'b1;
                  if (digit_count_ff == '0) begin
                     zero_upd = (digit_val[3:0] == 4'd0);
                  end
               end
            end else if (char_byte == ipv4dq_pkg::CHAR_DOT) begin
               if ((digit_count_ff == '0) || (field_index_ff == ipv4dq_pkg::LAST_FIELD)) begin
                  error_upd = 1'b1;
               end else begin
                  partial_upd[field_index_ff*ipv4dq_pkg::OCTET_W +: ipv4dq_pkg::OCTET_W] =
                     octet_value_ff;
                  field_upd = field_index_ff + 1'b1;
                  octet_upd = '0;
                  digit_upd = '0;
                  zero_upd  = 1'b0;
               end
            end else begin
               error_upd = 1'b1;
            end
         end
      end
   end

   // Judge the whole string from the updated state.
   assign addr_ok          = !error_upd && (field_upd == ipv4dq_pkg::LAST_FIELD) &&
                             (digit_upd != '0);
   assign result.valid_res = addr_ok;
   assign result.address   = addr_ok ? {octet_upd, partial_upd} : '0;

   // The last byte returns the state to its cleared form.
   always_comb begin
      octet_value_in     = octet_value_ff;
      digit_count_in     = digit_count_ff;
      field_index_in     = field_index_ff;
      partial_address_in = partial_address_ff;
      char_count_in      = char_count_ff;
      leading_zero_in    = leading_zero_ff;
      error_seen_in      = error_seen_ff;
      if (step_en) begin
         if (last_byte) begin
            octet_value_in     = '0;
            digit_count_in     = '0;
            field_index_in     = '0;
            partial_address_in = '0;
            char_count_in      = '0;
            leading_zero_in    = 1'b0;
            error_seen_in      = 1'b0;
         end else begin
            octet_value_in     = octet_upd;
            digit_count_in     = digit_upd;
            field_index_in     = field_upd;
            partial_address_in = partial_upd;
            char_count_in      = count_upd;
            leading_zero_in    = zero_upd;
            error_seen_in      = error_upd;
         end
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         octet_value_ff     <= '0;
         digit_count_ff     <= '0;
         field_index_ff     <= '0;
         partial_address_ff <= '0;
         char_count_ff      <= '0;
         leading_zero_ff    <= 1'b0;
         error_seen_ff      <= 1'b0;
      end else begin
         octet_value_ff     <= octet_value_in;
         digit_count_ff     <= digit_count_in;
         field_index_ff     <= field_index_in;
         partial_address_ff <= partial_address_in;
         char_count_ff      <= char_count_in;
         leading_zero_ff    <= leading_zero_in;
         error_seen_ff      <= error_seen_in;
      end
   end

endmodule

// ===== rtl/ipv4_dotted_quad_parser_unit.sv =====
// Top level of the strict dotted-quad IPv4 address parser.
//
//   Channel  Direction  Carries
//   req_*    in         one character per transaction, tlast on the final one
//   rsp_*    out        one address and a valid flag per string
//
// Each character is held in the input register, where the scanner
// updates the parse state; a final character also loads the result register.
// A new character is taken every cycle, except while a final character waits
// in the input register because the result register is full and not drained.
// Reset is synchronous and clears the parse state and both valid flags.
module ipv4_dotted_quad_parser_unit #(
   parameter int unsigned MAX_CHARS = ipv4dq_pkg::MAX_CHARS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // char_byte[7:0]
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [31:0]                        rsp_tdata,  // address[31:0]
   output logic [0:0]                         rsp_tuser   // valid_res[0]
);

   logic                              in_valid_ff, in_valid_in;
   logic [ipv4dq_pkg::CHAR_W-1:0]     in_char_ff;
   logic                              in_last_ff;
   logic                              out_valid_ff, out_valid_in;
   ipv4dq_pkg::result_type            out_result_ff;
   ipv4dq_pkg::result_type            scan_result;
   logic                              out_free;
   logic                              step_en;
   logic                              req_take;

   // A stored character moves on unless it ends a string and the result slot is busy.
   assign out_free    = !out_valid_ff || rsp_tready;
   assign step_en     = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready  = !in_valid_ff || step_en;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !step_en);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   ipv4dq_field_scan #(
      .MAX_CHARS (MAX_CHARS)
   ) u_field_scan (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .char_byte (in_char_ff),
      .last_byte (in_last_ff),
      .result    (scan_result)
   );

   // Result register loads on a final character and empties on a taken transaction.
   assign out_valid_in = (step_en && in_last_ff) || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (step_en && in_last_ff) begin
         out_result_ff <= scan_result;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_result_ff.address;
   assign rsp_tuser[0] = out_result_ff.valid_res;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the strict dotted-quad IPv4 address parser.
module tb;

   typedef logic [ipv4dq_pkg::CHAR_W-1:0] char_q_type[$];

   localparam int RANDOM_CHARS  = 1000;
   localparam int QUIET_CHARS   = 200;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SINK_HOLD_LEN = 120;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = '0;  // char_byte[7:0]
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;        // address[31:0]
   logic [0:0]        rsp_tuser;        // valid_res[0]

   // Parse state of the predictor.
   logic [ipv4dq_pkg::OCTET_W-1:0]       scan_octet   = '0;
   logic [ipv4dq_pkg::DIGIT_COUNT_W-1:0] scan_digits  = '0;
   logic [ipv4dq_pkg::FIELD_IDX_W-1:0]   scan_field   = '0;
   logic [ipv4dq_pkg::PARTIAL_W-1:0]     scan_partial = '0;
   logic [ipv4dq_pkg::CHAR_COUNT_W-1:0]  scan_count   = '0;
   logic                                 scan_lead    = 1'b0;
   logic                                 scan_error   = 1'b0;

   ipv4dq_pkg::result_type addresses_due[$];
   int          mismatch_count = 0;
   int          chars_sent     = 0;
   int          cycle_count    = 0;
   bit          idle_enable    = 1'b1;
   int unsigned sink_hold_req  = 0;
   int unsigned sink_hold_left = 0;
   int unsigned sink_gap_left  = 0;

   ipv4_dotted_quad_parser_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Global watchdog on the cycle count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Advance the predicted parse state by one character; a final character
   // queues the expected address and clears the state for the next string.
   task automatic parse_char(input logic [ipv4dq_pkg::CHAR_W-1:0] ch, input logic last);
      int                     next_val;
      logic                   ok;
      ipv4dq_pkg::result_type res;
      if (!scan_error) begin
         if (scan_count >= ipv4dq_pkg::CHAR_LIMIT) begin
            scan_error = 1'b1;
         end else begin
            scan_count = scan_count + 1'b1;
            if (ch >= ipv4dq_pkg::CHAR_ZERO && ch <= ipv4dq_pkg::CHAR_NINE) begin
               if (scan_digits >= ipv4dq_pkg::MAX_DIGITS) begin
                  scan_error = 1'b1;
               end else if (scan_digits != 0 && scan_lead) begin
                  scan_error = 1'b1;
               end else begin
                  if (scan_digits == 0) begin
                     scan_lead = (ch == ipv4dq_pkg::CHAR_ZERO);
                  end
                  next_val = int'(scan_octet) * 10 + int'(ch - ipv4dq_pkg::CHAR_ZERO);
                  if (next_val > int'(ipv4dq_pkg::OCTET_MAX)) begin
                     scan_error = 1'b1;
                  end else begin
                     scan_octet  = ipv4dq_pkg::OCTET_W'(next_val);
                     scan_digits = scan_digits + 1'b1;
                  end
               end
            end else if (ch == ipv4dq_pkg::CHAR_DOT) begin
               if (scan_digits == 0 || scan_field >= ipv4dq_pkg::LAST_FIELD) begin
                  scan_error = 1'b1;
               end else begin
                  scan_partial[scan_field*8 +: 8] = scan_octet;
                  scan_field  = scan_field + 1'b1;
                  scan_octet  = '0;
                  scan_digits = '0;
                  scan_lead   = 1'b0;
               end
            end else begin
               scan_error = 1'b1;
            end
         end
      end
      if (last) begin
         ok = !scan_error && scan_field == ipv4dq_pkg::LAST_FIELD && scan_digits != 0;
         res.valid_res = ok;
         res.address   = ok ? {scan_octet, scan_partial} : '0;
         addresses_due.push_back(res);
         scan_octet   = '0;
         scan_digits  = '0;
         scan_field   = '0;
         scan_partial = '0;
         scan_count   = '0;
         scan_lead    = 1'b0;
         scan_error   = 1'b0;
      end
   endtask

   // Watch both channels: predict on each input transaction and compare
   // each result transaction with the oldest expected address.
   always @(posedge clock) begin
      ipv4dq_pkg::result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            parse_char(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (addresses_due.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10) begin
                  $display("unexpected result: address %h valid %0b",
                           rsp_tdata, rsp_tuser[0]);
               end
            end else begin
               want = addresses_due.pop_front();
               if (rsp_tdata !== want.address || rsp_tuser[0] !== want.valid_res) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: address exp %h got %h, valid exp %0b got %0b",
                              want.address, rsp_tdata, want.valid_res, rsp_tuser[0]);
                  end
               end
            end
         end
      end
   end

   // Result receiver: random stall bursts plus a long hold on request.
   always @(posedge clock) begin
      if (sink_hold_req != 0) begin
         sink_hold_left = sink_hold_req;
         sink_hold_req  = 0;
      end
      if (sink_hold_left != 0) begin
         sink_hold_left = sink_hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (sink_gap_left != 0) begin
         sink_gap_left = sink_gap_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         sink_gap_left = $urandom_range(1, 6) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic char_q_type chars_of(input string text);
      char_q_type q;
      for (int i = 0; i < text.len(); i++) q.push_back(ipv4dq_pkg::CHAR_W'(text[i]));
      return q;
   endfunction

   // Random decimal digit character.
   function automatic logic [ipv4dq_pkg::CHAR_W-1:0] digit_char(input int lo, input int hi);
      return ipv4dq_pkg::CHAR_W'(ipv4dq_pkg::CHAR_ZERO +
                                 ipv4dq_pkg::CHAR_W'($urandom_range(lo, hi)));
   endfunction

   // Octet value biased toward the field-width boundaries.
   function automatic int octet_pick();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 9);
         1: return $urandom_range(10, 99);
         2: return $urandom_range(100, 255);
         3: return 0;
         default: return 255;
      endcase
   endfunction

   function automatic string quad_text();
      return $sformatf("%0d.%0d.%0d.%0d", octet_pick(), octet_pick(), octet_pick(),
                       octet_pick());
   endfunction

   // Offer one character and wait for its transaction; valid stays high after.
   task automatic send_char(input logic [ipv4dq_pkg::CHAR_W-1:0] ch, input logic last);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      chars_sent = chars_sent + 1;
   endtask

   task automatic send_chars(input char_q_type q);
      for (int i = 0; i < q.size(); i++) send_char(q[i], i == q.size() - 1);
   endtask

   // Stop offering and wait until every expected address has arrived.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (addresses_due.size() != 0);
   endtask

   // Valid extremes and every rejection rule.
   task automatic test_directed_cases();
      string      cases[] = '{
         "0.0.0.0", "255.255.255.255", "10.0.99.100", "100.100.100.100",
         "256.1.1.1", "1.1.1.300", "01.2.3.4", "1.2.3.00", "1.2.3.1000",
         ".1.2.3", "1..2.3", "1.2.3.", "1.2.3.4.5", "1.2.3", "7",
         "1/2.3.4", "1.2:3.4", "100.100.100.1000", "1a2.3.4.5.6.7.8.9.0.1.2"};
      char_q_type q;
      foreach (cases[i]) send_chars(chars_of(cases[i]));
      q = chars_of("1.2.3.4");
      q[6] = 8'h00;
      send_chars(q);
      q[6] = 8'hFF;
      send_chars(q);
      wait_for_results();
   endtask

   // Hold the receiver off for a long stretch while characters keep coming,
   // so the block fills up and stalls its input.
   task automatic test_result_backpressure();
      idle_enable   = 1'b0;
      sink_hold_req = SINK_HOLD_LEN;
      repeat (30) begin
         if ($urandom_range(0, 2) == 0) begin
            send_chars(chars_of($sformatf("%0d", $urandom_range(0, 9))));
         end else begin
            send_chars(chars_of(quad_text()));
         end
      end
      wait_for_results();
      idle_enable = 1'b1;
   endtask

   // Mostly well-formed addresses, some corrupted, some pure noise.
   task automatic test_random_strings();
      char_q_type q;
      int         first;
      int         done;
      int         pick;
      int         pos;
      first = chars_sent;
      done  = 0;
      while (done < RANDOM_CHARS) begin
         idle_enable = (done < RANDOM_CHARS - QUIET_CHARS) && ((done / 250) % 3 != 2);
         pick = $urandom_range(0, 19);
         if (pick < 17) begin
            q = chars_of(quad_text());
            if (pick >= 12) begin
               pos = $urandom_range(0, q.size() - 1);
               case ($urandom_range(0, 5))
                  0: q[pos] = ipv4dq_pkg::CHAR_W'($urandom_range(0, 255));
                  1: q.insert(pos, ($urandom_range(0, 1) != 0) ? ipv4dq_pkg::CHAR_DOT :
                              digit_char(0, 9));
                  2: if (q.size() > 1) q.delete(pos);
                  3: q.push_front(ipv4dq_pkg::CHAR_ZERO);
                  4: begin
                     q.push_back(ipv4dq_pkg::CHAR_DOT);
                     q.push_back(digit_char(1, 9));
                  end
                  default: q = chars_of($sformatf("%0d.%0d.%0d.%0d", octet_pick(),
                                        $urandom_range(256, 999), octet_pick(),
                                        octet_pick()));
               endcase
            end
         end else begin
            q = {};
            repeat ($urandom_range(1, 20)) begin
               pos = $urandom_range(0, 9);
               if (pos < 5) q.push_back(digit_char(0, 9));
               else if (pos < 7) q.push_back(ipv4dq_pkg::CHAR_DOT);
               else q.push_back(ipv4dq_pkg::CHAR_W'($urandom_range(0, 255)));
            end
         end
         send_chars(q);
         done = chars_sent - first;
      end
   endtask

   // Test sequence.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_result_backpressure();
      test_random_strings();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && addresses_due.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
